// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL modules; chmi_ctrl uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with the reset held off.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/chmi_pkg.sv -----
`default_nettype none
package chmi_pkg;

    localparam int CAPACITY = 256;
    localparam int BUCKETS  = 512;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int BKT_W    = $clog2(BUCKETS);

    localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_HEAD,
        S_HEAD_WAIT,
        S_CMP,
        S_LINK_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic mix1;
        logic mix2;
        logic mix3;
        logic head_rd;
        logic head_take;
        logic step;
        logic key_rd;
        logic wr_replace;
        logic wr_append;
        logic set_full;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic cur_valid;
        logic key_match;
        logic store_full;
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/core/chmi_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
module chmi_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  chmi_pkg::t_status i_status,
    output chmi_pkg::t_cmd   o_cmd
);

    chmi_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chmi_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            chmi_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = chmi_pkg::S_IDLE;
                end
            end
            chmi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = chmi_pkg::S_MIX1;
                end
            end
            chmi_pkg::S_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state    = chmi_pkg::S_MIX2;
            end
            chmi_pkg::S_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = chmi_pkg::S_MIX3;
            end
            chmi_pkg::S_MIX3: begin
                o_cmd.mix3 = 1'b1;
                n_state    = chmi_pkg::S_HEAD;
            end
            chmi_pkg::S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = chmi_pkg::S_HEAD_WAIT;
            end
            chmi_pkg::S_HEAD_WAIT: begin
                o_cmd.head_take = 1'b1;
                n_state         = chmi_pkg::S_CMP;
            end
            chmi_pkg::S_CMP: begin
                if (r_out_valid && !i_out_ready) begin
                    n_state = chmi_pkg::S_CMP;
                end else if (i_status.cur_valid && i_status.key_match) begin
                    o_cmd.wr_replace = 1'b1;
                    n_state          = chmi_pkg::S_DONE;
                end else if (i_status.cur_valid) begin
                    o_cmd.step = 1'b1;
                    n_state    = chmi_pkg::S_LINK_WAIT;
                end else if (i_status.store_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = chmi_pkg::S_DONE;
                end else begin
                    o_cmd.wr_append = 1'b1;
                    n_state         = chmi_pkg::S_DONE;
                end
            end
            chmi_pkg::S_LINK_WAIT: begin
                o_cmd.key_rd = 1'b1;
                n_state      = chmi_pkg::S_CMP;
            end
            chmi_pkg::S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = chmi_pkg::S_IDLE;
            end
            default: begin
                n_state = chmi_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_done_sets_valid, r_state == chmi_pkg::S_DONE |=> r_out_valid, "no result")
    `ASSERT_CLK(a_busy_not_ready, r_state != chmi_pkg::S_IDLE |-> !o_in_ready, "ready busy")
    `ASSERT_CLK(a_one_write, !(o_cmd.wr_replace && o_cmd.wr_append), "two writes")

endmodule
`default_nettype wire

// ----- rtl/core/chmi_datapath.sv -----
`default_nettype none
module chmi_datapath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [31:0]        i_key,
    input  wire  [31:0]        i_value,
    input  chmi_pkg::t_cmd     i_cmd,
    output chmi_pkg::t_status  o_status,
    output logic               o_replaced,
    output logic               o_full_res,
    output logic [7:0]         o_slot
);

    localparam int IW = chmi_pkg::IDX_W;
    localparam int CW = chmi_pkg::CNT_W;
    localparam int BW = chmi_pkg::BKT_W;

    logic [IW:0]   r_heads [chmi_pkg::BUCKETS];
    logic [IW:0]   r_links [chmi_pkg::CAPACITY];
    logic [31:0]   r_keys  [chmi_pkg::CAPACITY];
    logic [31:0]   r_vals  [chmi_pkg::CAPACITY];

    logic [31:0]   r_key, r_value, r_h;
    logic [BW-1:0] r_bkt;
    logic [BW-1:0] r_clr;
    logic [IW:0]   r_head_rd, r_cur;
    logic [31:0]   r_key_rd;
    logic [CW-1:0] r_count;
    logic          r_replaced, r_full;
    logic [IW-1:0] r_slot;

    logic [31:0] w_m1, w_m2;
    assign w_m1 = (r_h ^ (r_h >> 16)) * chmi_pkg::MIX_C1;
    assign w_m2 = (r_h ^ (r_h >> 13)) * chmi_pkg::MIX_C2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.wr_append) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_heads[r_clr] <= '0;
        end
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_value <= i_value;
            r_h     <= i_key;
        end
        if (i_cmd.mix1) begin
            r_h <= w_m1;
        end
        if (i_cmd.mix2) begin
            r_h <= w_m2;
        end
        if (i_cmd.mix3) begin
            r_bkt <= BW'(r_h ^ (r_h >> 16));
        end
        if (i_cmd.head_rd) begin
            r_head_rd <= r_heads[r_bkt];
        end
        if (i_cmd.head_take) begin
            r_cur    <= r_head_rd;
            r_key_rd <= r_keys[r_head_rd[IW-1:0]];
        end
        if (i_cmd.step) begin
            r_cur <= r_links[r_cur[IW-1:0]];
        end
        if (i_cmd.key_rd) begin
            r_key_rd <= r_keys[r_cur[IW-1:0]];
        end
        if (i_cmd.wr_replace) begin
            r_vals[r_cur[IW-1:0]] <= r_value;
            r_replaced <= 1'b1;
            r_full     <= 1'b0;
            r_slot     <= r_cur[IW-1:0];
        end
        if (i_cmd.wr_append) begin
            r_links[r_count[IW-1:0]] <= r_head_rd;
            r_keys[r_count[IW-1:0]]  <= r_key;
            r_vals[r_count[IW-1:0]]  <= r_value;
            r_heads[r_bkt]           <= {1'b1, r_count[IW-1:0]};
            r_replaced <= 1'b0;
            r_full     <= 1'b0;
            r_slot     <= r_count[IW-1:0];
        end
        if (i_cmd.set_full) begin
            r_replaced <= 1'b0;
            r_full     <= 1'b1;
            r_slot     <= '0;
        end
    end

    assign o_status.clear_done = &r_clr;
    assign o_status.cur_valid  = r_cur[IW];
    assign o_status.key_match  = (r_key_rd == r_key);
    assign o_status.store_full = r_count[IW];
    assign o_replaced = r_replaced;
    assign o_full_res = r_full;
    assign o_slot     = 8'(r_slot);

endmodule
`default_nettype wire

// ----- rtl/core/chained_hash_map_insert.sv -----
`default_nettype none
// Inserts or updates 32-bit key/value pairs in a separately chained hash table
// of 256 entries and 512 buckets, bucket chosen by the low bits of fmix32(key).
// After reset the bucket heads are cleared in one pass over all 512 buckets,
// during which no request is accepted. A request passes the hash steps MIX1,
// MIX2, MIX3, the head read HEAD, HEAD_WAIT, then the compare, each chain step
// going through LINK_WAIT, and its result is made valid from DONE. The next
// request is accepted while a result waits, but its compare stalls until that
// result is taken. One result per request: the slot index in tdata, the
// replaced and full flags in tuser.
module chained_hash_map_insert (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // key[31:0], value[63:32]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // slot[7:0]
    output logic [1:0]  m_axis_tuser    // replaced[0], full_res[1]
);

    chmi_pkg::t_cmd    w_cmd;
    chmi_pkg::t_status w_status;
    logic              w_replaced, w_full;
    logic [7:0]        w_slot;

    chmi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    chmi_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (s_axis_tdata[31:0]),
        .i_value    (s_axis_tdata[63:32]),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_replaced (w_replaced),
        .o_full_res (w_full),
        .o_slot     (w_slot)
    );

    assign m_axis_tdata = w_slot;
    assign m_axis_tuser = {w_full, w_replaced};

endmodule
`default_nettype wire
